/* rtl/bps_pkg.sv */
package bps_pkg;

  // Field widths of the request and result payload
  localparam int POS_FIELD_W = 24;
  localparam int VEL_FIELD_W = 16;
  localparam int HP_W        = 16;
  localparam int LIFE_W      = 16;

  // Register widths
  localparam int MAXV_W   = 15;
  localparam int ELAST_W  = 12;
  localparam int THRESH_W = 15;

  // Defaults for the top-level parameters
  localparam int POS_WIDTH_DEF = 24;
  localparam int VEL_WIDTH_DEF = 16;

  // Downward velocity change applied on every moving tick
  localparam int GRAVITY_STEP = 32;

  // Configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic {
    REQ_TICK   = 1'b0,
    REQ_LAUNCH = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    REG_TYPE_VALID    = 3'd0,
    REG_MAX_VELOCITY  = 3'd1,
    REG_WILL_BOUNCE   = 3'd2,
    REG_ELASTICITY    = 3'd3,
    REG_BOUNCE_THRESH = 3'd4,
    REG_IMPACT_DAMAGE = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic                type_valid;
    logic [MAXV_W-1:0]   max_velocity;
    logic                will_bounce;
    logic [ELAST_W-1:0]  elasticity_q8;
    logic [THRESH_W-1:0] bounce_threshold;
    logic                impact_damage_enabled;
  } cfg_t;

endpackage

/* rtl/bps_sat.sv */
module bps_sat #(
  parameter int IN_W  = 17,
  parameter int OUT_W = 16
) (
  input  logic signed [IN_W-1:0]  value_i,
  output logic signed [OUT_W-1:0] value_o
);

  logic [IN_W-OUT_W:0] upper;
  logic                fits;

  // Value fits when all bits above the result sign agree with it
  assign upper = value_i[IN_W-1:OUT_W-1];
  assign fits  = (&upper) | ~(|upper);

  // Pass through, or pin to the most negative / most positive code
  always_comb begin
    if (fits) begin
      value_o = value_i[OUT_W-1:0];
    end else if (value_i[IN_W-1]) begin
      value_o = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      value_o = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

endmodule

/* rtl/bps_step.sv */
module bps_step #(
  parameter int POS_WIDTH = bps_pkg::POS_WIDTH_DEF,
  parameter int VEL_WIDTH = bps_pkg::VEL_WIDTH_DEF
) (
  input  bps_pkg::cfg_t                                cfg_i,
  input  bps_pkg::req_type_e                           req_type_i,
  input  logic signed [bps_pkg::POS_FIELD_W-1:0]       start_pos_i [3],
  input  logic signed [bps_pkg::VEL_FIELD_W-1:0]       start_vel_i [3],
  input  logic signed [bps_pkg::HP_W-1:0]              start_health_i,
  input  logic        [bps_pkg::LIFE_W-1:0]            start_lifetime_i,
  input  logic                                         active_i,
  input  logic signed [POS_WIDTH-1:0]                  pos_i [3],
  input  logic signed [VEL_WIDTH-1:0]                  vel_i [3],
  input  logic signed [bps_pkg::HP_W-1:0]              hp_i,
  input  logic        [bps_pkg::LIFE_W-1:0]            ticks_i,
  input  logic                                         impact_i,
  output logic                                         active_o,
  output logic signed [POS_WIDTH-1:0]                  pos_o [3],
  output logic signed [VEL_WIDTH-1:0]                  vel_o [3],
  output logic signed [bps_pkg::HP_W-1:0]              hp_o,
  output logic        [bps_pkg::LIFE_W-1:0]            ticks_o,
  output logic                                         impact_o
);

  import bps_pkg::*;

  // Intermediate widths
  localparam int GW   = VEL_WIDTH + 12;
  localparam int CW   = ((VEL_WIDTH > MAXV_W + 1) ? VEL_WIDTH : MAXV_W + 1) + 1;
  localparam int SW   = ((POS_WIDTH > VEL_WIDTH) ? POS_WIDTH : VEL_WIDTH) + 1;
  localparam int LPW  = ((POS_WIDTH > POS_FIELD_W) ? POS_WIDTH : POS_FIELD_W) + 1;
  localparam int LVW  = ((VEL_WIDTH > VEL_FIELD_W) ? VEL_WIDTH : VEL_FIELD_W) + 1;
  localparam int PRW  = VEL_WIDTH + ELAST_W + 2;

  logic signed [POS_WIDTH-1:0] launch_pos [3];
  logic signed [VEL_WIDTH-1:0] launch_vel [3];
  logic signed [GW-1:0]        vz_grav_w;
  logic signed [VEL_WIDTH-1:0] vz_grav;
  logic signed [VEL_WIDTH-1:0] vel_pre [3];
  logic signed [VEL_WIDTH-1:0] vel_mv [3];
  logic signed [POS_WIDTH-1:0] pos_mv [3];
  logic signed [VEL_WIDTH-1:0] vel_half [2];
  logic signed [CW-1:0]        max_pos;
  logic signed [CW-1:0]        max_neg;
  logic signed [VEL_WIDTH:0]   neg_vz;
  logic signed [ELAST_W:0]     elast_s;
  logic signed [PRW-1:0]       prod;
  logic signed [PRW-1:0]       prod_adj;
  logic signed [PRW-1:0]       speed;
  logic signed [VEL_WIDTH-1:0] vz_rebound;
  logic                        rebound;
  logic                        bounce_en;
  logic                        ground;
  logic                        expire;
  logic [LIFE_W-1:0]           ticks_dec;

  // Launch values, saturated into the state widths
  for (genvar a = 0; a < 3; a++) begin : g_launch
    logic signed [LPW-1:0] pos_w;
    logic signed [LVW-1:0] vel_w;

    assign pos_w = LPW'(start_pos_i[a]);
    assign vel_w = LVW'(start_vel_i[a]);

    bps_sat #(.IN_W(LPW), .OUT_W(POS_WIDTH)) u_sat_lpos (
      .value_i(pos_w), .value_o(launch_pos[a])
    );
    bps_sat #(.IN_W(LVW), .OUT_W(VEL_WIDTH)) u_sat_lvel (
      .value_i(vel_w), .value_o(launch_vel[a])
    );
  end

  // Apply gravity to the vertical velocity
  assign vz_grav_w = GW'(vel_i[2]) - $signed(GW'(GRAVITY_STEP));

  bps_sat #(.IN_W(GW), .OUT_W(VEL_WIDTH)) u_sat_grav (
    .value_i(vz_grav_w), .value_o(vz_grav)
  );

  assign max_pos = $signed(CW'(cfg_i.max_velocity));
  assign max_neg = -max_pos;

  // Clamp each axis, then move the position
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [CW-1:0]        v_w;
    logic signed [CW-1:0]        v_clamp_w;
    logic signed [VEL_WIDTH-1:0] v_clamp;
    logic signed [SW-1:0]        p_sum;

    assign vel_pre[a] = (a == 2) ? vz_grav : vel_i[a];
    assign v_w        = CW'(vel_pre[a]);

    always_comb begin
      if (v_w < max_neg) begin
        v_clamp_w = max_neg;
      end else if (v_w > max_pos) begin
        v_clamp_w = max_pos;
      end else begin
        v_clamp_w = v_w;
      end
    end

    bps_sat #(.IN_W(CW), .OUT_W(VEL_WIDTH)) u_sat_clamp (
      .value_i(v_clamp_w), .value_o(v_clamp)
    );

    assign vel_mv[a] = (cfg_i.max_velocity != '0) ? v_clamp : vel_pre[a];
    assign p_sum     = SW'(pos_i[a]) + SW'(vel_mv[a]);

    bps_sat #(.IN_W(SW), .OUT_W(POS_WIDTH)) u_sat_pos (
      .value_i(p_sum), .value_o(pos_mv[a])
    );
  end

  // Halve horizontal velocity, rounding toward zero
  for (genvar a = 0; a < 2; a++) begin : g_half
    logic signed [VEL_WIDTH-1:0] v_bias;

    assign v_bias      = vel_mv[a] + VEL_WIDTH'(vel_mv[a][VEL_WIDTH-1]);
    assign vel_half[a] = v_bias >>> 1;
  end

  // Rebound speed: scale the upward speed by elasticity, truncate toward zero
  assign neg_vz   = -(VEL_WIDTH + 1)'(vel_mv[2]);
  assign elast_s  = $signed({1'b0, cfg_i.elasticity_q8});
  assign prod     = PRW'(neg_vz) * PRW'(elast_s);
  assign prod_adj = prod + (prod[PRW-1] ? PRW'(255) : PRW'(0));
  assign speed    = prod_adj >>> 8;
  assign rebound  = speed > $signed(PRW'(cfg_i.bounce_threshold));

  bps_sat #(.IN_W(PRW), .OUT_W(VEL_WIDTH)) u_sat_reb (
    .value_i(speed), .value_o(vz_rebound)
  );

  assign bounce_en = cfg_i.will_bounce && (cfg_i.elasticity_q8 != '0);
  assign ground    = (pos_mv[2] <= $signed(POS_WIDTH'(0)));
  assign expire    = (ticks_i == LIFE_W'(1));
  assign ticks_dec = (ticks_i != '0) ? ticks_i - LIFE_W'(1) : ticks_i;

  // Select the state after this request
  always_comb begin
    active_o = active_i;
    pos_o    = pos_i;
    vel_o    = vel_i;
    hp_o     = hp_i;
    ticks_o  = ticks_i;
    impact_o = impact_i;

    if (req_type_i == REQ_LAUNCH) begin
      active_o = 1'b1;
      pos_o    = launch_pos;
      vel_o    = launch_vel;
      hp_o     = start_health_i;
      ticks_o  = start_lifetime_i;
      impact_o = 1'b0;
    end else if (active_i) begin
      if (!cfg_i.type_valid) begin
        active_o = 1'b0;
      end else if (expire) begin
        active_o = 1'b0;
        ticks_o  = ticks_dec;
      end else begin
        ticks_o = ticks_dec;
        pos_o   = pos_mv;
        vel_o   = vel_mv;
        if (ground) begin
          pos_o[2] = '0;
          if (bounce_en && rebound) begin
            vel_o[2] = vz_rebound;
            vel_o[0] = vel_half[0];
            vel_o[1] = vel_half[1];
          end else begin
            // Come to rest on the ground
            vel_o[0] = '0;
            vel_o[1] = '0;
            vel_o[2] = '0;
            impact_o = impact_i | cfg_i.impact_damage_enabled;
            active_o = 1'b0;
          end
        end
        if (hp_i <= $signed(HP_W'(0))) begin
          active_o = 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/bouncing_particle_step.sv */
// Bouncing debris particle stepper. Each request either launches the
// particle (loads position, velocity, health and lifetime) or ticks it one
// frame (gravity, per-axis velocity clamp, move, ground bounce or rest), and
// each request yields exactly one result: the particle state after it.
// A request is registered on input, stepped by one pass of combinational
// logic into the result register, and the result register is the particle
// state itself, so one request per clock is sustained while the output is
// not stalled. A stalled result holds the state, and the input stage then
// holds at most one more request. Registers are written through the APB
// port at byte address 4*i and must only change while no request is in
// flight.
module bouncing_particle_step #(
  parameter int POS_WIDTH = bps_pkg::POS_WIDTH_DEF,
  parameter int VEL_WIDTH = bps_pkg::VEL_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Request channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   req_type_i,
  input  logic signed [bps_pkg::POS_FIELD_W-1:0] start_x_i,
  input  logic signed [bps_pkg::POS_FIELD_W-1:0] start_y_i,
  input  logic signed [bps_pkg::POS_FIELD_W-1:0] start_z_i,
  input  logic signed [bps_pkg::VEL_FIELD_W-1:0] start_vx_i,
  input  logic signed [bps_pkg::VEL_FIELD_W-1:0] start_vy_i,
  input  logic signed [bps_pkg::VEL_FIELD_W-1:0] start_vz_i,
  input  logic signed [bps_pkg::HP_W-1:0]        start_health_i,
  input  logic        [bps_pkg::LIFE_W-1:0]      start_lifetime_i,
  // Result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   active_o,
  output logic signed [bps_pkg::POS_FIELD_W-1:0] pos_x_o,
  output logic signed [bps_pkg::POS_FIELD_W-1:0] pos_y_o,
  output logic signed [bps_pkg::POS_FIELD_W-1:0] pos_z_o,
  output logic signed [bps_pkg::VEL_FIELD_W-1:0] vel_x_o,
  output logic signed [bps_pkg::VEL_FIELD_W-1:0] vel_y_o,
  output logic signed [bps_pkg::VEL_FIELD_W-1:0] vel_z_o,
  output logic        [bps_pkg::LIFE_W-1:0]      lifetime_left_o,
  output logic                                   impact_marked_o,
  // Configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic        [bps_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic        [bps_pkg::APB_DATA_W-1:0]  pwdata,
  output logic        [bps_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                   pready
);

  import bps_pkg::*;

  localparam int PEW = (POS_WIDTH > POS_FIELD_W) ? POS_WIDTH : POS_FIELD_W;
  localparam int VEW = (VEL_WIDTH > VEL_FIELD_W) ? VEL_WIDTH : VEL_FIELD_W;

  cfg_t                           cfg_q;
  cfg_reg_e                       reg_sel;
  logic                           cfg_wr;

  logic                           in_full_q;
  req_type_e                      req_type_q;
  logic signed [POS_FIELD_W-1:0]  start_pos_q [3];
  logic signed [VEL_FIELD_W-1:0]  start_vel_q [3];
  logic signed [HP_W-1:0]         start_health_q;
  logic        [LIFE_W-1:0]       start_lifetime_q;

  logic                           out_full_q;
  logic                           active_q, active_d;
  logic signed [POS_WIDTH-1:0]    pos_q [3];
  logic signed [POS_WIDTH-1:0]    pos_d [3];
  logic signed [VEL_WIDTH-1:0]    vel_q [3];
  logic signed [VEL_WIDTH-1:0]    vel_d [3];
  logic signed [HP_W-1:0]         hp_q, hp_d;
  logic        [LIFE_W-1:0]       ticks_q, ticks_d;
  logic                           impact_q, impact_d;

  logic                           in_take;
  logic                           advance;
  logic signed [PEW-1:0]          pos_ext [3];
  logic signed [VEW-1:0]          vel_ext [3];

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.type_valid            <= 1'b1;
      cfg_q.max_velocity          <= '0;
      cfg_q.will_bounce           <= 1'b0;
      cfg_q.elasticity_q8         <= '0;
      cfg_q.bounce_threshold      <= '0;
      cfg_q.impact_damage_enabled <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_TYPE_VALID:    cfg_q.type_valid            <= pwdata[0];
        REG_MAX_VELOCITY:  cfg_q.max_velocity          <= pwdata[MAXV_W-1:0];
        REG_WILL_BOUNCE:   cfg_q.will_bounce           <= pwdata[0];
        REG_ELASTICITY:    cfg_q.elasticity_q8         <= pwdata[ELAST_W-1:0];
        REG_BOUNCE_THRESH: cfg_q.bounce_threshold      <= pwdata[THRESH_W-1:0];
        REG_IMPACT_DAMAGE: cfg_q.impact_damage_enabled <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_sel)
      REG_TYPE_VALID:    prdata = APB_DATA_W'(cfg_q.type_valid);
      REG_MAX_VELOCITY:  prdata = APB_DATA_W'(cfg_q.max_velocity);
      REG_WILL_BOUNCE:   prdata = APB_DATA_W'(cfg_q.will_bounce);
      REG_ELASTICITY:    prdata = APB_DATA_W'(cfg_q.elasticity_q8);
      REG_BOUNCE_THRESH: prdata = APB_DATA_W'(cfg_q.bounce_threshold);
      REG_IMPACT_DAMAGE: prdata = APB_DATA_W'(cfg_q.impact_damage_enabled);
      default:           prdata = '0;
    endcase
  end

  // Handshake: step when a request waits and the result slot is free or leaving
  assign advance     = in_full_q && (!out_full_q || !out_stall_i);
  assign in_stall_o  = in_full_q && out_full_q && out_stall_i;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q  <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      in_full_q  <= in_take || (in_full_q && !advance);
      out_full_q <= advance || (out_full_q && out_stall_i);
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_type_q       <= req_type_e'(req_type_i);
      start_pos_q[0]   <= start_x_i;
      start_pos_q[1]   <= start_y_i;
      start_pos_q[2]   <= start_z_i;
      start_vel_q[0]   <= start_vx_i;
      start_vel_q[1]   <= start_vy_i;
      start_vel_q[2]   <= start_vz_i;
      start_health_q   <= start_health_i;
      start_lifetime_q <= start_lifetime_i;
    end
  end

  bps_step #(
    .POS_WIDTH(POS_WIDTH),
    .VEL_WIDTH(VEL_WIDTH)
  ) u_bps_step (
    .cfg_i           (cfg_q),
    .req_type_i      (req_type_q),
    .start_pos_i     (start_pos_q),
    .start_vel_i     (start_vel_q),
    .start_health_i  (start_health_q),
    .start_lifetime_i(start_lifetime_q),
    .active_i        (active_q),
    .pos_i           (pos_q),
    .vel_i           (vel_q),
    .hp_i            (hp_q),
    .ticks_i         (ticks_q),
    .impact_i        (impact_q),
    .active_o        (active_d),
    .pos_o           (pos_d),
    .vel_o           (vel_d),
    .hp_o            (hp_d),
    .ticks_o         (ticks_d),
    .impact_o        (impact_d)
  );

  // Particle state, which doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '{default: '0};
      vel_q    <= '{default: '0};
      hp_q     <= HP_W'(1);
      ticks_q  <= '0;
      impact_q <= 1'b0;
    end else if (advance) begin
      active_q <= active_d;
      pos_q    <= pos_d;
      vel_q    <= vel_d;
      hp_q     <= hp_d;
      ticks_q  <= ticks_d;
      impact_q <= impact_d;
    end
  end

  // Fit the state widths onto the result fields
  for (genvar a = 0; a < 3; a++) begin : g_out
    assign pos_ext[a] = PEW'(pos_q[a]);
    assign vel_ext[a] = VEW'(vel_q[a]);
  end

  assign active_o        = active_q;
  assign pos_x_o         = pos_ext[0][POS_FIELD_W-1:0];
  assign pos_y_o         = pos_ext[1][POS_FIELD_W-1:0];
  assign pos_z_o         = pos_ext[2][POS_FIELD_W-1:0];
  assign vel_x_o         = vel_ext[0][VEL_FIELD_W-1:0];
  assign vel_y_o         = vel_ext[1][VEL_FIELD_W-1:0];
  assign vel_z_o         = vel_ext[2][VEL_FIELD_W-1:0];
  assign lifetime_left_o = ticks_q;
  assign impact_marked_o = impact_q;

endmodule

/* rtl/bps_checker.sv */
module bps_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic                                   active_o,
  input logic signed [bps_pkg::POS_FIELD_W-1:0] pos_x_o,
  input logic signed [bps_pkg::POS_FIELD_W-1:0] pos_y_o,
  input logic signed [bps_pkg::POS_FIELD_W-1:0] pos_z_o,
  input logic signed [bps_pkg::VEL_FIELD_W-1:0] vel_x_o,
  input logic signed [bps_pkg::VEL_FIELD_W-1:0] vel_y_o,
  input logic signed [bps_pkg::VEL_FIELD_W-1:0] vel_z_o,
  input logic        [bps_pkg::LIFE_W-1:0]      lifetime_left_o,
  input logic                                   impact_marked_o
);

  // Hold a stalled result steady
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(active_o) && $stable(pos_x_o) && $stable(pos_y_o)
      && $stable(pos_z_o) && $stable(vel_x_o) && $stable(vel_y_o)
      && $stable(vel_z_o) && $stable(lifetime_left_o) && $stable(impact_marked_o))
    else $error("stalled result changed");

  // Stall requests only while a finished result is held back
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled without a blocked result");

  // Every accepted request leaves a result in place after the input and result registers
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("no result after accepted request");

endmodule

bind bouncing_particle_step bps_checker u_bps_checker (.*);
